FILE: design/abc_pkg.sv
// ----------------------------------------------------------------------------
// abc_pkg: ambient brightness controller package
// Widths, register map, mode codes, state encoding and divider handshake types.
// ----------------------------------------------------------------------------
`default_nettype none

package abc_pkg;

	localparam int LEVEL_W  = 7;
	localparam int LIGHT_W  = 15;
	localparam int HOUR_W   = 5;
	localparam int MINUTE_W = 6;
	localparam int MOD_W    = 11;   // minute of day, also holds out of range times
	localparam int OFFS_W   = 16;
	localparam int DEN_W    = 15;
	localparam int NUM_W    = 17;   // magnitude of light_sum - light_offset
	localparam int DIFF_W   = NUM_W + 1;
	localparam int DIV_STEPS = NUM_W;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

	localparam int DATA_W = 32;
	localparam int ADDR_W = 5;
	localparam int IDX_W  = 3;

	// register map, index = paddr / 4
	localparam logic [IDX_W-1:0] REG_MODE        = 3'd0;
	localparam logic [IDX_W-1:0] REG_LIGHT_OFFS  = 3'd1;
	localparam logic [IDX_W-1:0] REG_LIGHT_DIV   = 3'd2;
	localparam logic [IDX_W-1:0] REG_MAX_LEVEL   = 3'd3;
	localparam logic [IDX_W-1:0] REG_DAY_START   = 3'd4;
	localparam logic [IDX_W-1:0] REG_NIGHT_START = 3'd5;
	localparam logic [IDX_W-1:0] REG_DAY_LEVEL   = 3'd6;
	localparam logic [IDX_W-1:0] REG_NIGHT_LEVEL = 3'd7;

	localparam logic [1:0] MODE_FIXED  = 2'd0;
	localparam logic [1:0] MODE_SENSOR = 2'd1;
	localparam logic [1:0] MODE_SCHED  = 2'd2;

	localparam logic [1:0] DL_NIGHT   = 2'd0;
	localparam logic [1:0] DL_DAY     = 2'd1;
	localparam logic [1:0] DL_UNKNOWN = 2'd2;

	localparam logic [1:0]         RST_MODE        = MODE_FIXED;
	localparam logic [OFFS_W-1:0]  RST_LIGHT_OFFS  = 16'd0;
	localparam logic [DEN_W-1:0]   RST_LIGHT_DIV   = 15'd327;
	localparam logic [LEVEL_W-1:0] RST_MAX_LEVEL   = 7'd100;
	localparam logic [MOD_W-1:0]   RST_DAY_START   = 11'd540;
	localparam logic [MOD_W-1:0]   RST_NIGHT_START = 11'd1365;
	localparam logic [LEVEL_W-1:0] RST_DAY_LEVEL   = 7'd20;
	localparam logic [LEVEL_W-1:0] RST_NIGHT_LEVEL = 7'd2;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_DIV  = 3'b010,
		ST_DONE = 3'b100
	} state_t;

	typedef struct packed {
		logic             start;
		logic [NUM_W-1:0] num;
		logic [DEN_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [NUM_W-1:0] quot;
	} div_rsp_t;

endpackage

`default_nettype wire

FILE: design/abc_if.sv
// ----------------------------------------------------------------------------
// abc_if: ambient brightness controller channels
// Valid/ready channels for the tick word and the brightness word.
// ----------------------------------------------------------------------------
`default_nettype none

interface abc_in_if;
	logic                          valid;
	logic                          ready;
	logic [abc_pkg::LIGHT_W-1:0]   light_sum;
	logic [abc_pkg::HOUR_W-1:0]    hour;
	logic [abc_pkg::MINUTE_W-1:0]  minute;

	modport source (output valid, light_sum, hour, minute, input ready);
	modport sink   (input valid, light_sum, hour, minute, output ready);
endinterface

interface abc_out_if;
	logic                          valid;
	logic                          ready;
	logic [abc_pkg::LEVEL_W-1:0]   brightness;
	logic                          is_day;

	modport source (output valid, brightness, is_day, input ready);
	modport sink   (input valid, brightness, is_day, output ready);
endinterface

`default_nettype wire

FILE: design/ambient_brightness_controller.sv
// Sensor mode: the tick word starts the serial divider, which shifts in one quotient bit
// per step; the sequencer waits in DIV for done, then loads the brightness word in DONE.
// Other modes go straight to DONE. The input is ready only in IDLE, so a new tick word
// is not taken while the divider runs or while DONE waits for the output to be free.
// Reset (arst_n low, asynchronous): registers to their defaults, daylight state
// unknown, output word dropped.
// ----------------------------------------------------------------------------
// ambient_brightness_controller: display brightness from light and time of day
// Sensor level by serial division, day/night schedule, fixed level, APB config.
// ----------------------------------------------------------------------------
`default_nettype none

module ambient_brightness_controller #(
	parameter int MIN_LEVEL = 5
) (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        psel,
	input  wire                        penable,
	input  wire                        pwrite,
	input  wire [abc_pkg::ADDR_W-1:0]  paddr,
	input  wire [abc_pkg::DATA_W-1:0]  pwdata,
	output logic [abc_pkg::DATA_W-1:0] prdata,
	output logic                       pready,
	abc_in_if.sink                     in_ch,
	abc_out_if.source                  out_ch
);

	localparam logic [abc_pkg::NUM_W-1:0] LV_MIN = abc_pkg::NUM_W'(MIN_LEVEL);

	// configuration registers
	logic [1:0]                     mode_q;
	logic [abc_pkg::OFFS_W-1:0]     light_offs_q;
	logic [abc_pkg::DEN_W-1:0]      light_div_q;
	logic [abc_pkg::LEVEL_W-1:0]    max_level_q;
	logic [abc_pkg::MOD_W-1:0]      day_start_q;
	logic [abc_pkg::MOD_W-1:0]      night_start_q;
	logic [abc_pkg::LEVEL_W-1:0]    day_level_q;
	logic [abc_pkg::LEVEL_W-1:0]    night_level_q;

	logic                           cfg_wr;
	logic [abc_pkg::IDX_W-1:0]      cfg_idx;

	abc_pkg::state_t                state_q;
	logic [1:0]                     daylight_q;
	logic                           emit_q;
	logic                           sensor_q;
	logic                           neg_q;
	logic                           is_day_q;
	logic [abc_pkg::LEVEL_W-1:0]    level_q;

	logic                           out_valid_q;
	logic [abc_pkg::LEVEL_W-1:0]    brightness_q;
	logic                           out_is_day_q;

	logic                           in_acc;
	logic [abc_pkg::MOD_W-1:0]      now;
	logic                           day;
	logic signed [abc_pkg::DIFF_W-1:0] diff;
	logic                           diff_neg;
	logic [abc_pkg::DIFF_W-1:0]     diff_abs;
	logic                           sched_change;
	logic                           out_free;

	abc_pkg::div_req_t              div_req;
	abc_pkg::div_rsp_t              div_rsp;

	logic                           q_lt;
	logic [abc_pkg::NUM_W-1:0]      q_min;
	logic [abc_pkg::NUM_W-1:0]      q_pos;
	logic [abc_pkg::LEVEL_W-1:0]    sensor_level;
	logic [abc_pkg::LEVEL_W-1:0]    final_level;

	// ------------------------------------------------------------------ config
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign cfg_idx = paddr[abc_pkg::ADDR_W-1:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q        <= abc_pkg::RST_MODE;
			light_offs_q  <= abc_pkg::RST_LIGHT_OFFS;
			light_div_q   <= abc_pkg::RST_LIGHT_DIV;
			max_level_q   <= abc_pkg::RST_MAX_LEVEL;
			day_start_q   <= abc_pkg::RST_DAY_START;
			night_start_q <= abc_pkg::RST_NIGHT_START;
			day_level_q   <= abc_pkg::RST_DAY_LEVEL;
			night_level_q <= abc_pkg::RST_NIGHT_LEVEL;
		end else if (cfg_wr) begin
			case (cfg_idx)
				abc_pkg::REG_MODE:        mode_q        <= pwdata[1:0];
				abc_pkg::REG_LIGHT_OFFS:  light_offs_q  <= pwdata[abc_pkg::OFFS_W-1:0];
				abc_pkg::REG_LIGHT_DIV:   light_div_q   <= pwdata[abc_pkg::DEN_W-1:0];
				abc_pkg::REG_MAX_LEVEL:   max_level_q   <= pwdata[abc_pkg::LEVEL_W-1:0];
				abc_pkg::REG_DAY_START:   day_start_q   <= pwdata[abc_pkg::MOD_W-1:0];
				abc_pkg::REG_NIGHT_START: night_start_q <= pwdata[abc_pkg::MOD_W-1:0];
				abc_pkg::REG_DAY_LEVEL:   day_level_q   <= pwdata[abc_pkg::LEVEL_W-1:0];
				abc_pkg::REG_NIGHT_LEVEL: night_level_q <= pwdata[abc_pkg::LEVEL_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		case (cfg_idx)
			abc_pkg::REG_MODE:        prdata = abc_pkg::DATA_W'(mode_q);
			abc_pkg::REG_LIGHT_OFFS:  prdata = abc_pkg::DATA_W'(light_offs_q);
			abc_pkg::REG_LIGHT_DIV:   prdata = abc_pkg::DATA_W'(light_div_q);
			abc_pkg::REG_MAX_LEVEL:   prdata = abc_pkg::DATA_W'(max_level_q);
			abc_pkg::REG_DAY_START:   prdata = abc_pkg::DATA_W'(day_start_q);
			abc_pkg::REG_NIGHT_START: prdata = abc_pkg::DATA_W'(night_start_q);
			abc_pkg::REG_DAY_LEVEL:   prdata = abc_pkg::DATA_W'(day_level_q);
			abc_pkg::REG_NIGHT_LEVEL: prdata = abc_pkg::DATA_W'(night_level_q);
			default:                  prdata = '0;
		endcase
	end

	// ------------------------------------------------------------------ tick decode
	assign in_ch.ready = (state_q == abc_pkg::ST_IDLE);
	assign in_acc      = in_ch.valid && in_ch.ready;

	// hour * 60 as hour * 64 - hour * 4
	assign now = abc_pkg::MOD_W'({in_ch.hour, 6'b0}) - abc_pkg::MOD_W'({in_ch.hour, 2'b0})
	           + abc_pkg::MOD_W'(in_ch.minute);
	assign day = (now >= day_start_q) && (now < night_start_q);

	assign diff     = $signed({3'b0, in_ch.light_sum})
	                - $signed({{2{light_offs_q[abc_pkg::OFFS_W-1]}}, light_offs_q});
	assign diff_neg = diff[abc_pkg::DIFF_W-1];
	assign diff_abs = diff_neg ? -diff : diff;

	assign sched_change = (daylight_q != {1'b0, day});

	assign div_req.start = in_acc && (mode_q == abc_pkg::MODE_SENSOR);
	assign div_req.num   = diff_abs[abc_pkg::NUM_W-1:0];
	assign div_req.den   = (light_div_q == '0) ? abc_pkg::DEN_W'(1) : light_div_q;

	abc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// ------------------------------------------------------------------ sensor clamp
	// raise to the minimum (negative quotients too), never zero, then cap
	assign q_lt  = (neg_q && (div_rsp.quot != '0)) || (div_rsp.quot < LV_MIN);
	assign q_min = q_lt ? LV_MIN : div_rsp.quot;
	assign q_pos = (q_min == '0) ? abc_pkg::NUM_W'(1) : q_min;
	assign sensor_level = (q_pos > abc_pkg::NUM_W'(max_level_q)) ? max_level_q
	                    : q_pos[abc_pkg::LEVEL_W-1:0];
	assign final_level  = sensor_q ? sensor_level : level_q;

	assign out_free = !out_valid_q || out_ch.ready;

	// ------------------------------------------------------------------ sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= abc_pkg::ST_IDLE;
			daylight_q <= abc_pkg::DL_UNKNOWN;
			emit_q     <= 1'b0;
			sensor_q   <= 1'b0;
		end else begin
			case (state_q)
				abc_pkg::ST_IDLE: begin
					if (in_acc) begin
						sensor_q <= (mode_q == abc_pkg::MODE_SENSOR);
						if (mode_q == abc_pkg::MODE_SENSOR) begin
							emit_q  <= 1'b1;
							state_q <= abc_pkg::ST_DIV;
						end else if (mode_q == abc_pkg::MODE_SCHED) begin
							emit_q     <= sched_change;
							daylight_q <= day ? abc_pkg::DL_DAY : abc_pkg::DL_NIGHT;
							state_q    <= abc_pkg::ST_DONE;
						end else begin
							emit_q  <= 1'b1;
							state_q <= abc_pkg::ST_DONE;
						end
					end
				end
				abc_pkg::ST_DIV: begin
					if (div_rsp.done) begin
						state_q <= abc_pkg::ST_DONE;
					end
				end
				abc_pkg::ST_DONE: begin
					if (out_free || !emit_q) begin
						state_q <= abc_pkg::ST_IDLE;
					end
				end
				default: state_q <= abc_pkg::ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			neg_q    <= diff_neg;
			is_day_q <= day;
			level_q  <= (mode_q == abc_pkg::MODE_SCHED && !day) ? night_level_q : day_level_q;
		end
	end

	// ------------------------------------------------------------------ output word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == abc_pkg::ST_DONE && emit_q && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == abc_pkg::ST_DONE && emit_q && out_free) begin
			brightness_q <= final_level;
			out_is_day_q <= is_day_q;
		end
	end

	assign out_ch.valid      = out_valid_q;
	assign out_ch.brightness = brightness_q;
	assign out_ch.is_day     = out_is_day_q;

endmodule

`default_nettype wire

FILE: design/abc_div.sv
// ----------------------------------------------------------------------------
// abc_div: restoring divider
// Unsigned divide, one quotient bit per cycle, done pulse on the last step.
// ----------------------------------------------------------------------------
`default_nettype none

module abc_div (
	input  wire                clk,
	input  wire                arst_n,
	input  abc_pkg::div_req_t  req,
	output abc_pkg::div_rsp_t  rsp
);

	logic [abc_pkg::DIV_CNT_W-1:0] cnt_q;
	logic                          done_q;
	logic [abc_pkg::DEN_W-1:0]     rem_q;
	logic [abc_pkg::DEN_W-1:0]     den_q;
	logic [abc_pkg::NUM_W-1:0]     quo_q;

	logic [abc_pkg::DEN_W:0]       trial;
	logic [abc_pkg::DEN_W:0]       diff;
	logic                          ge;

	// shift in next numerator bit, subtract when it fits
	assign trial = {rem_q, quo_q[abc_pkg::NUM_W-1]};
	assign diff  = trial - {1'b0, den_q};
	assign ge    = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				cnt_q <= abc_pkg::DIV_CNT_W'(abc_pkg::DIV_STEPS);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == abc_pkg::DIV_CNT_W'(1)) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			den_q <= req.den;
			quo_q <= req.num;
		end else if (cnt_q != '0) begin
			rem_q <= ge ? diff[abc_pkg::DEN_W-1:0] : trial[abc_pkg::DEN_W-1:0];
			quo_q <= {quo_q[abc_pkg::NUM_W-2:0], ge};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = quo_q;

endmodule

`default_nettype wire

FILE: design/abc_chk.sv
// ----------------------------------------------------------------------------
// abc_chk: ambient brightness controller port checker
// Watches the top level ports and flags handshake and sequencing slips.
// ----------------------------------------------------------------------------
`default_nettype none

module abc_chk (
	input wire                         clk,
	input wire                         arst_n,
	input wire                         pready,
	input wire                         in_valid,
	input wire                         in_ready,
	input wire                         out_valid,
	input wire                         out_ready,
	input wire [abc_pkg::LEVEL_W-1:0]  out_brightness,
	input wire                         out_is_day
);

	// the input is not ready in the cycle after a tick word is taken
	a_busy_after_tick: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input ready right after a tick word");

	// stalled output word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_brightness)
		&& $stable(out_is_day))
		else $error("output word changed while stalled");

	// no word on the output right after reset
	a_reset_quiet: assert property (@(posedge clk)
		$rose(arst_n) |-> !out_valid)
		else $error("output valid out of reset");

	a_pready: assert property (@(posedge clk) disable iff (!arst_n)
		pready)
		else $error("config port stalled");

endmodule

bind ambient_brightness_controller abc_chk u_abc_chk (
	.clk            (clk),
	.arst_n         (arst_n),
	.pready         (pready),
	.in_valid       (in_ch.valid),
	.in_ready       (in_ch.ready),
	.out_valid      (out_ch.valid),
	.out_ready      (out_ch.ready),
	.out_brightness (out_ch.brightness),
	.out_is_day     (out_ch.is_day)
);

`default_nettype wire
